// ===== rtl/lav_pkg.sv =====
`timescale 1ns / 1ps
package lav_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // The largest magnitude of a vector is aligned so that its top bit sits at NORM_TOP - 1.
    localparam int NORM_TOP  = 30;
    localparam int VEC_W     = COORD_WIDTH + 1;
    localparam int LEN_W     = $clog2(VEC_W + 1);
    localparam int SQR_W     = 2 * NORM_TOP;
    localparam int SUM_W     = SQR_W + 2;
    localparam int SQ_W      = SUM_W + 2;
    localparam int SQ_STEPS  = NORM_TOP + 1;
    localparam int ROOT_W    = NORM_TOP + 1;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int DIV_STEPS = QUO_W;
    localparam int REM_W     = ROOT_W + FRAC_BITS;
    localparam int UNIT_W    = FRAC_BITS + 2;
    localparam int AXIS_W    = FRAC_BITS + 4;
    localparam int PROD_W    = 2 * AXIS_W;
    localparam int DOT_W     = AXIS_W + COORD_WIDTH + 2;

    localparam int UNIT_LAT  = 5 + SQ_STEPS + DIV_STEPS + 1;
    localparam int CROSS_LAT = 2;
    localparam int DOT_LAT   = 2;
    localparam int EYE_DLY   = UNIT_LAT + 2 * CROSS_LAT;
    localparam int F_DLY     = 2 * CROSS_LAT;
    localparam int OK_DLY    = 2 * CROSS_LAT + DOT_LAT;

    localparam int NUM_ROWS  = 4;
    localparam int GAP_W     = $clog2(NUM_ROWS);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [VEC_W-1:0]       t_wide;
    typedef logic signed [UNIT_W-1:0]      t_unit;
    typedef logic signed [AXIS_W-1:0]      t_axis;

    typedef enum logic [1:0] {
        ROW_SIDE,
        ROW_UP,
        ROW_FWD,
        ROW_HOMOG
    } t_row;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        t_coord w;
    } t_row_data;

    function automatic t_coord axis_to_coord(t_axis a);
        return {{(COORD_WIDTH - AXIS_W){a[AXIS_W-1]}}, a};
    endfunction

endpackage

// ===== rtl/lav_unitize.sv =====
`timescale 1ns / 1ps
module lav_unitize (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lav_pkg::t_wide i_vec [3],
    output logic           o_valid,
    output lav_pkg::t_unit o_unit [3],
    output logic           o_ok
);
    import lav_pkg::*;

    typedef logic [VEC_W-1:0] t_mag;

    typedef struct packed {
        logic [2:0][NORM_TOP-1:0] m;
        logic [2:0]               neg;
        logic                     zero;
    } t_side;

    typedef struct packed {
        logic [SQ_W-1:0] x;
        logic [SQ_W-1:0] res;
        t_side           side;
    } t_sq;

    typedef struct packed {
        logic [ROOT_W-1:0]       n;
        logic [2:0][REM_W-1:0]   rem;
        logic [2:0][QUO_W-1:0]   q;
        logic [2:0]              neg;
        logic                    zero;
    } t_div;

    // One digit of the integer square root per stage.
    function automatic t_sq sq_step(t_sq s, int k);
        t_sq             o;
        logic [SQ_W-1:0] bit_v;
        logic [SQ_W-1:0] trial;
        o     = s;
        bit_v = SQ_W'(1) << (2 * k);
        trial = s.res + bit_v;
        if (s.x >= trial) begin
            o.x   = s.x - trial;
            o.res = (s.res >> 1) + bit_v;
        end else begin
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    // One quotient bit of each of the three restoring divisions per stage.
    function automatic t_div div_step(t_div d, int sh);
        t_div             o;
        logic [REM_W-1:0] dv;
        o  = d;
        dv = REM_W'(d.n) << sh;
        for (int c = 0; c < 3; c++) begin
            if (d.rem[c] >= dv) begin
                o.rem[c]    = d.rem[c] - dv;
                o.q[c][sh]  = 1'b1;
            end
        end
        return o;
    endfunction

    logic [UNIT_LAT-1:0] r_vld;

    t_mag            r_a_mag [3];
    logic [2:0]      r_a_neg;
    t_mag            n_a_mag [3];
    logic [2:0]      n_a_neg;

    t_mag            r_b_mag [3];
    logic [2:0]      r_b_neg;
    logic [LEN_W-1:0] r_b_len;
    logic            r_b_zero;
    logic [LEN_W-1:0] n_b_len;
    logic            n_b_zero;

    t_side           r_c_side;
    t_side           n_c_side;

    logic [SQR_W-1:0] r_d_sq [3];
    logic [SQR_W-1:0] n_d_sq [3];
    t_side            r_d_side;

    t_sq             r_sq [SQ_STEPS+1];
    t_sq             n_sq [SQ_STEPS+1];

    t_div            s_div0;
    t_div            r_div [1:DIV_STEPS];
    t_div            n_div [1:DIV_STEPS];

    t_unit           r_unit [3];
    logic            r_ok;
    t_unit           n_unit [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_neg[i] = i_vec[i][VEC_W-1];
            n_a_mag[i] = n_a_neg[i] ? t_mag'(~i_vec[i] + 1'b1) : t_mag'(i_vec[i]);
        end
    end

    always_comb begin
        t_mag mx;
        mx = r_a_mag[0];
        if (r_a_mag[1] > mx) mx = r_a_mag[1];
        if (r_a_mag[2] > mx) mx = r_a_mag[2];
        n_b_len = '0;
        for (int i = 0; i < VEC_W; i++) begin
            if (mx[i]) n_b_len = LEN_W'(i + 1);
        end
        n_b_zero = (mx == '0);
    end

    always_comb begin
        logic [VEC_W+NORM_TOP-1:0] wide;
        n_c_side.neg  = r_b_neg;
        n_c_side.zero = r_b_zero;
        for (int i = 0; i < 3; i++) begin
            wide          = {r_b_mag[i], {NORM_TOP{1'b0}}} >> r_b_len;
            n_c_side.m[i] = wide[NORM_TOP-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d_sq[i] = SQR_W'(r_c_side.m[i]) * SQR_W'(r_c_side.m[i]);
        end
    end

    always_comb begin
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(r_d_sq[0]) + SUM_W'(r_d_sq[1]) + SUM_W'(r_d_sq[2]);
        n_sq[0].x    = SQ_W'(sum);
        n_sq[0].res  = '0;
        n_sq[0].side = r_d_side;
        for (int j = 1; j <= SQ_STEPS; j++) begin
            n_sq[j] = sq_step(r_sq[j-1], SQ_STEPS - j);
        end
    end

    always_comb begin
        s_div0.n    = r_sq[SQ_STEPS].res[ROOT_W-1:0];
        s_div0.neg  = r_sq[SQ_STEPS].side.neg;
        s_div0.zero = r_sq[SQ_STEPS].side.zero;
        s_div0.q    = '0;
        for (int c = 0; c < 3; c++) begin
            s_div0.rem[c] = REM_W'({r_sq[SQ_STEPS].side.m[c], {FRAC_BITS{1'b0}}});
        end
        n_div[1] = div_step(s_div0, QUO_W - 1);
        for (int j = 2; j <= DIV_STEPS; j++) begin
            n_div[j] = div_step(r_div[j-1], QUO_W - j);
        end
    end

    always_comb begin
        t_unit qs;
        for (int c = 0; c < 3; c++) begin
            qs = t_unit'({1'b0, r_div[DIV_STEPS].q[c]});
            if (r_div[DIV_STEPS].zero) begin
                n_unit[c] = '0;
            end else begin
                n_unit[c] = r_div[DIV_STEPS].neg[c] ? -qs : qs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[UNIT_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mag  <= n_a_mag;
        r_a_neg  <= n_a_neg;
        r_b_mag  <= r_a_mag;
        r_b_neg  <= r_a_neg;
        r_b_len  <= n_b_len;
        r_b_zero <= n_b_zero;
        r_c_side <= n_c_side;
        r_d_sq   <= n_d_sq;
        r_d_side <= r_c_side;
        for (int j = 0; j <= SQ_STEPS; j++) begin
            r_sq[j] <= n_sq[j];
        end
        for (int j = 1; j <= DIV_STEPS; j++) begin
            r_div[j] <= n_div[j];
        end
        r_unit <= n_unit;
        r_ok   <= !r_div[DIV_STEPS].zero;
    end

    assign o_valid = r_vld[UNIT_LAT-1];
    assign o_unit  = r_unit;
    assign o_ok    = r_ok;

endmodule

// ===== rtl/lav_cross.sv =====
`timescale 1ns / 1ps
module lav_cross (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lav_pkg::t_axis i_a [3],
    input  lav_pkg::t_axis i_b [3],
    output logic           o_valid,
    output lav_pkg::t_axis o_r [3]
);
    import lav_pkg::*;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PROD_W:0]   t_diff;

    logic [CROSS_LAT-1:0] r_vld;
    t_prod r_p [6];
    t_prod n_p [6];
    t_axis r_r [3];
    t_axis n_r [3];

    always_comb begin
        n_p[0] = t_prod'(i_a[1]) * t_prod'(i_b[2]);
        n_p[1] = t_prod'(i_a[2]) * t_prod'(i_b[1]);
        n_p[2] = t_prod'(i_a[2]) * t_prod'(i_b[0]);
        n_p[3] = t_prod'(i_a[0]) * t_prod'(i_b[2]);
        n_p[4] = t_prod'(i_a[0]) * t_prod'(i_b[1]);
        n_p[5] = t_prod'(i_a[1]) * t_prod'(i_b[0]);
    end

    // Arithmetic right shift rounds the fraction toward minus infinity.
    always_comb begin
        t_diff d;
        for (int i = 0; i < 3; i++) begin
            d      = t_diff'(r_p[2*i]) - t_diff'(r_p[2*i+1]);
            n_r[i] = t_axis'(d >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CROSS_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        r_r <= n_r;
    end

    assign o_valid = r_vld[CROSS_LAT-1];
    assign o_r     = r_r;

endmodule

// ===== rtl/lav_dot.sv =====
`timescale 1ns / 1ps
module lav_dot (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lav_pkg::t_axis  i_r [3],
    input  lav_pkg::t_coord i_e [3],
    output logic            o_valid,
    output lav_pkg::t_axis  o_r [3],
    output lav_pkg::t_coord o_w
);
    import lav_pkg::*;

    typedef logic signed [DOT_W-1:0] t_dsum;

    localparam t_dsum SAT_HI = t_dsum'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam t_dsum SAT_LO = -SAT_HI - t_dsum'(1);

    logic [DOT_LAT-1:0] r_vld;
    t_dsum  r_p [3];
    t_dsum  n_p [3];
    t_axis  r_r1 [3];
    t_axis  r_r2 [3];
    t_coord r_w;
    t_coord n_w;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_p[i] = t_dsum'(i_r[i]) * t_dsum'(i_e[i]);
        end
    end

    // The dot product is exact; it is floored once, negated and then saturated to the t_coord range.
    always_comb begin
        t_dsum sum;
        t_dsum ng;
        sum = r_p[0] + r_p[1] + r_p[2];
        ng  = -(sum >>> FRAC_BITS);
        if (ng > SAT_HI) begin
            n_w = t_coord'(SAT_HI);
        end else if (ng < SAT_LO) begin
            n_w = t_coord'(SAT_LO);
        end else begin
            n_w = t_coord'(ng);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DOT_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p  <= n_p;
        r_r1 <= i_r;
        r_r2 <= r_r1;
        r_w  <= n_w;
    end

    assign o_valid = r_vld[DOT_LAT-1];
    assign o_r     = r_r2;
    assign o_w     = r_w;

endmodule

// ===== rtl/look_at_view_matrix.sv =====
`timescale 1ns / 1ps
// View matrix from eye, center and up, all signed Q16.16.
// Input: drive the nine coordinates with i_start high; the beat is taken at a
// rising edge where o_busy is low. o_busy is then raised and counts down, so
// no new beat is taken until it falls again; this keeps the result port free,
// as the four matrix rows leave one per cycle over the single result port.
// Output: o_row_valid marks each row beat for one cycle. Rows come in order
// side, up, negated forward and the constant last row, on consecutive
// cycles, with o_last on the fourth and o_degenerate the same on all four.
// The path to the rows runs through the pipelined square root (31 stages) and
// the restoring dividers (17 stages) that normalize both vectors, then through
// the cross and dot products.
// The receiver has no way to stall; every row beat must be taken as it comes.
// Synchronous reset empties the pipeline and drops all beats in flight;
// o_busy is low after reset.
module look_at_view_matrix (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  lav_pkg::t_coord i_eye_x,
    input  lav_pkg::t_coord i_eye_y,
    input  lav_pkg::t_coord i_eye_z,
    input  lav_pkg::t_coord i_center_x,
    input  lav_pkg::t_coord i_center_y,
    input  lav_pkg::t_coord i_center_z,
    input  lav_pkg::t_coord i_up_x,
    input  lav_pkg::t_coord i_up_y,
    input  lav_pkg::t_coord i_up_z,
    output logic            o_busy,
    output logic            o_row_valid,
    output logic [1:0]      o_row_index,
    output lav_pkg::t_coord o_elem_x,
    output lav_pkg::t_coord o_elem_y,
    output lav_pkg::t_coord o_elem_z,
    output lav_pkg::t_coord o_elem_w,
    output logic            o_last,
    output logic            o_degenerate
);
    import lav_pkg::*;

    localparam t_coord ONE_FIX = t_coord'(64'd1 << FRAC_BITS);

    logic             accept;
    logic [GAP_W-1:0] r_gap;
    logic [GAP_W-1:0] n_gap;

    logic   r0_vld;
    t_coord r0_eye [3];
    t_wide  r0_fv  [3];
    t_wide  r0_up  [3];

    logic  f_vld, up_vld, f_ok, up_ok;
    t_unit f_unit  [3];
    t_unit up_unit [3];
    t_axis f_ax    [3];
    t_axis up_ax   [3];

    t_coord          r_eye_d [EYE_DLY][3];
    t_axis           r_fd    [F_DLY][3];
    t_axis           r_sd    [CROSS_LAT][3];
    logic [OK_DLY-1:0] r_okd;

    logic  s_vld, u_vld;
    t_axis s_vec [3];
    t_axis u_vec [3];
    t_axis nf    [3];

    logic   ds_vld, du_vld, df_vld, row_vld;
    t_axis  ds_r [3];
    t_axis  du_r [3];
    t_axis  df_r [3];
    t_coord ds_w, du_w, df_w;

    t_row      r_cnt, n_cnt;
    logic      r_out_vld, n_out_vld;
    logic      r_out_last, n_out_last;
    t_row      r_out_row, n_out_row;
    t_row_data r_out, n_out;
    t_row_data r_hold_u, n_hold_u;
    t_row_data r_hold_f, n_hold_f;
    logic      r_out_deg, n_out_deg;

    assign accept = i_start && !o_busy;
    assign o_busy = (r_gap != '0);

    always_comb begin
        if (accept) begin
            n_gap = GAP_W'(NUM_ROWS - 1);
        end else if (r_gap != '0) begin
            n_gap = r_gap - 1'b1;
        end else begin
            n_gap = r_gap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap  <= '0;
            r0_vld <= 1'b0;
        end else begin
            r_gap  <= n_gap;
            r0_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_eye[0] <= i_eye_x;
        r0_eye[1] <= i_eye_y;
        r0_eye[2] <= i_eye_z;
        r0_fv[0]  <= t_wide'(i_center_x) - t_wide'(i_eye_x);
        r0_fv[1]  <= t_wide'(i_center_y) - t_wide'(i_eye_y);
        r0_fv[2]  <= t_wide'(i_center_z) - t_wide'(i_eye_z);
        r0_up[0]  <= t_wide'(i_up_x);
        r0_up[1]  <= t_wide'(i_up_y);
        r0_up[2]  <= t_wide'(i_up_z);
    end

    lav_unitize u_unit_f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_vld),
        .i_vec   (r0_fv),
        .o_valid (f_vld),
        .o_unit  (f_unit),
        .o_ok    (f_ok)
    );

    lav_unitize u_unit_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_vld),
        .i_vec   (r0_up),
        .o_valid (up_vld),
        .o_unit  (up_unit),
        .o_ok    (up_ok)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f_ax[i]  = t_axis'(f_unit[i]);
            up_ax[i] = t_axis'(up_unit[i]);
            nf[i]    = -r_fd[F_DLY-1][i];
        end
    end

    // Delay lines keep eye, forward and side aligned with the later products.
    always_ff @(posedge i_clk) begin
        r_eye_d[0] <= r0_eye;
        for (int k = 1; k < EYE_DLY; k++) begin
            r_eye_d[k] <= r_eye_d[k-1];
        end
        r_fd[0] <= f_ax;
        for (int k = 1; k < F_DLY; k++) begin
            r_fd[k] <= r_fd[k-1];
        end
        r_sd[0] <= s_vec;
        for (int k = 1; k < CROSS_LAT; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
        r_okd <= {r_okd[OK_DLY-2:0], f_ok && up_ok};
    end

    lav_cross u_cross_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_vld && up_vld),
        .i_a     (f_ax),
        .i_b     (up_ax),
        .o_valid (s_vld),
        .o_r     (s_vec)
    );

    lav_cross u_cross_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_vld),
        .i_a     (s_vec),
        .i_b     (r_fd[CROSS_LAT-1]),
        .o_valid (u_vld),
        .o_r     (u_vec)
    );

    lav_dot u_dot_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (u_vld),
        .i_r     (r_sd[CROSS_LAT-1]),
        .i_e     (r_eye_d[EYE_DLY-1]),
        .o_valid (ds_vld),
        .o_r     (ds_r),
        .o_w     (ds_w)
    );

    lav_dot u_dot_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (u_vld),
        .i_r     (u_vec),
        .i_e     (r_eye_d[EYE_DLY-1]),
        .o_valid (du_vld),
        .o_r     (du_r),
        .o_w     (du_w)
    );

    lav_dot u_dot_f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (u_vld),
        .i_r     (nf),
        .i_e     (r_eye_d[EYE_DLY-1]),
        .o_valid (df_vld),
        .o_r     (df_r),
        .o_w     (df_w)
    );

    assign row_vld = ds_vld && du_vld && df_vld;

    // Row zero leaves as soon as a finished item arrives; the other rows are
    // held and sent in order up, forward and the constant row right after it, before the next item can arrive.
    always_comb begin
        n_cnt      = r_cnt;
        n_out_vld  = 1'b0;
        n_out_last = 1'b0;
        n_out_row  = r_out_row;
        n_out      = r_out;
        n_hold_u   = r_hold_u;
        n_hold_f   = r_hold_f;
        n_out_deg  = r_out_deg;
        if (row_vld) begin
            n_out_vld = 1'b1;
            n_out_row = ROW_SIDE;
            n_out     = '{axis_to_coord(ds_r[0]), axis_to_coord(ds_r[1]),
                          axis_to_coord(ds_r[2]), ds_w};
            n_hold_u  = '{axis_to_coord(du_r[0]), axis_to_coord(du_r[1]),
                          axis_to_coord(du_r[2]), du_w};
            n_hold_f  = '{axis_to_coord(df_r[0]), axis_to_coord(df_r[1]),
                          axis_to_coord(df_r[2]), df_w};
            n_out_deg = !r_okd[OK_DLY-1];
            n_cnt     = ROW_UP;
        end else begin
            case (r_cnt)
                ROW_SIDE: begin
                end
                ROW_UP: begin
                    n_out_vld = 1'b1;
                    n_out_row = ROW_UP;
                    n_out     = r_hold_u;
                    n_cnt     = ROW_FWD;
                end
                ROW_FWD: begin
                    n_out_vld = 1'b1;
                    n_out_row = ROW_FWD;
                    n_out     = r_hold_f;
                    n_cnt     = ROW_HOMOG;
                end
                ROW_HOMOG: begin
                    n_out_vld  = 1'b1;
                    n_out_last = 1'b1;
                    n_out_row  = ROW_HOMOG;
                    n_out      = '{'0, '0, '0, ONE_FIX};
                    n_cnt      = ROW_SIDE;
                end
                default: begin
                    n_cnt = ROW_SIDE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= ROW_SIDE;
            r_out_vld  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_cnt      <= n_cnt;
            r_out_vld  <= n_out_vld;
            r_out_last <= n_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_row <= n_out_row;
        r_out     <= n_out;
        r_hold_u  <= n_hold_u;
        r_hold_f  <= n_hold_f;
        r_out_deg <= n_out_deg;
    end

    assign o_row_valid  = r_out_vld;
    assign o_row_index  = r_out_row;
    assign o_elem_x     = r_out.x;
    assign o_elem_y     = r_out.y;
    assign o_elem_z     = r_out.z;
    assign o_elem_w     = r_out.w;
    assign o_last       = r_out_last;
    assign o_degenerate = r_out_deg;

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_row_valid && o_row_index == ROW_SIDE) |=> (o_row_valid && o_row_index == ROW_UP))
        else $error("row after the side row is not the up row");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy)
        else $error("busy not raised after an accepted beat");

    a_degenerate_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_row_valid && !o_last) |=> $stable(o_degenerate))
        else $error("degenerate flag changed within one matrix");

    a_unit_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_vld == up_vld)
        else $error("normalizer pipelines out of step");

endmodule
